// ===== design/gmig_pkg.sv =====
`default_nettype none
package gmig_pkg;

   localparam int INDEX_WIDTH = 24;
   localparam int CFG_WIDTH   = 13;
   localparam int COUNT_WIDTH = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int IDX_COUNT_W = 3;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = ((6 * INDEX_WIDTH + IDX_COUNT_W + 7) / 8) * 8;
   localparam int RSP_USER_W  = 2;
   localparam int PROD_WIDTH  = 3 * CFG_WIDTH;

   localparam longint unsigned MAX_POINTS = 64'd1 << INDEX_WIDTH;

   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [CFG_WIDTH-1:0]   cfg_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam cfg_type CFG_MAX = 13'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_COUNT = 2'd0,
      CSR_ROWS    = 2'd1,
      CSR_LAYERS  = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_DONE = 5'b00001,
      PH_LINE = 5'b00010,
      PH_CELL = 5'b00100,
      PH_FB   = 5'b01000,
      PH_LR   = 5'b10000
   } phase_type;

   typedef enum logic [RSP_USER_W-1:0] {
      ST_OK           = 2'd0,
      ST_EXHAUSTED    = 2'd1,
      ST_BAD_GEOMETRY = 2'd2
   } status_type;

   localparam logic [IDX_COUNT_W-1:0] IDX_NONE    = 3'd0;
   localparam logic [IDX_COUNT_W-1:0] IDX_SEGMENT = 3'd2;
   localparam logic [IDX_COUNT_W-1:0] IDX_QUAD    = 3'd6;

   // settled view of the configuration, shared by the step logic
   typedef struct packed {
      cfg_type   x_count;
      cfg_type   x_minus_1;
      cfg_type   rows;
      cfg_type   layers;
      index_type layer_points;
      index_type points_minus_x;
      logic      ok;
      phase_type start_phase;
      phase_type after_cell_phase;
      phase_type after_fb_phase;
   } geom_type;

endpackage
`default_nettype wire

// ===== design/gmig_geom.sv =====
`default_nettype none
module gmig_geom (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [gmig_pkg::CSR_INDEX_W-1:0] csr_index,
   input  gmig_pkg::cfg_type                csr_wdata,
   output gmig_pkg::geom_type               geom,
   output logic                             busy
);
   import gmig_pkg::*;

   cfg_type   x_count_ff, rows_ff, layers_ff;
   logic [1:0] settle_ff, settle_in;

   logic [2*CFG_WIDTH-1:0] points_ff;
   cfg_type   x_minus_1_ff;
   logic      range_ok_ff;
   phase_type start_phase_ff, after_cell_ff, after_fb_ff;
   index_type points_minus_x_ff;
   logic      ok_ff;

   logic      range_ok_in;
   phase_type start_phase_in, after_cell_in, after_fb_in;
   phase_type line_ph, cell_ph, fb_ph, lr_ph;
   logic [PROD_WIDTH-1:0] total;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_count_ff <= 13'd2;
         rows_ff    <= 13'd1;
         layers_ff  <= 13'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_X_COUNT: x_count_ff <= csr_wdata;
            CSR_ROWS:    rows_ff    <= csr_wdata;
            CSR_LAYERS:  layers_ff  <= csr_wdata;
            default:     x_count_ff <= x_count_ff;
         endcase
      end
   end

   // settle count that holds busy while the product pipeline catches up with a write
   always_comb begin
      if (csr_write) begin
         settle_in = 2'd2;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 2'd2;
      end else begin
         settle_ff <= settle_in;
      end
   end

   always_comb begin
      range_ok_in = (x_count_ff != '0) && (x_count_ff <= CFG_MAX)
                 && (rows_ff != '0) && (rows_ff <= CFG_MAX)
                 && (layers_ff != '0) && (layers_ff <= CFG_MAX)
                 && !((rows_ff == 13'd1) && (layers_ff > 13'd1));
      lr_ph   = ((layers_ff < 13'd2) || (rows_ff < 13'd2)) ? PH_DONE : PH_LR;
      fb_ph   = ((layers_ff < 13'd2) || (x_count_ff < 13'd2)) ? lr_ph : PH_FB;
      after_cell_in = (layers_ff > 13'd1) ? fb_ph : PH_DONE;
      cell_ph = ((x_count_ff < 13'd2) || (rows_ff < 13'd2)) ? after_cell_in : PH_CELL;
      line_ph = (x_count_ff < 13'd2) ? PH_DONE : PH_LINE;
      start_phase_in = ((rows_ff == 13'd1) && (layers_ff == 13'd1)) ? line_ph : cell_ph;
      after_fb_in    = lr_ph;
   end

   always_ff @(posedge clock) begin
      points_ff      <= (2*CFG_WIDTH)'(x_count_ff) * (2*CFG_WIDTH)'(rows_ff);
      x_minus_1_ff   <= x_count_ff - 13'd1;
      range_ok_ff    <= range_ok_in;
      start_phase_ff <= start_phase_in;
      after_cell_ff  <= after_cell_in;
      after_fb_ff    <= after_fb_in;
   end

   assign total = PROD_WIDTH'(points_ff) * PROD_WIDTH'(layers_ff);

   always_ff @(posedge clock) begin
      points_minus_x_ff <= index_type'(points_ff) - index_type'(x_count_ff);
      ok_ff             <= range_ok_ff && (total <= PROD_WIDTH'(MAX_POINTS));
   end

   always_comb begin
      geom.x_count          = x_count_ff;
      geom.x_minus_1        = x_minus_1_ff;
      geom.rows             = rows_ff;
      geom.layers           = layers_ff;
      geom.layer_points     = index_type'(points_ff);
      geom.points_minus_x   = points_minus_x_ff;
      geom.ok               = ok_ff;
      geom.start_phase      = start_phase_ff;
      geom.after_cell_phase = after_cell_ff;
      geom.after_fb_phase   = after_fb_ff;
   end

   assign busy = (settle_ff != 2'd0);

endmodule
`default_nettype wire

// ===== design/grid_mesh_index_generator_unit.sv =====
`default_nettype none
// Grid mesh index generator: each request (restart bit in req_tdata) yields exactly one
// response the next cycle, holding one primitive of the pass over the configured grid:
// a line segment for a single row, two triangles per cell for one layer, and for several
// layers the cells, then front/back faces, then left/right faces. One request is taken
// every cycle while no register write is settling and the response register is free or
// being drained in the same cycle. A register write ends the pass in progress, and
// after it (and after reset) req_tready is low while the pipelined points product and
// geometry checks settle.
module grid_mesh_index_generator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gmig_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] restart
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [23:0] tri0_a, [47:24] tri0_b, [71:48] tri0_c, [95:72] tri1_a,
   // [119:96] tri1_b, [143:120] tri1_c, [146:144] index_count
   output logic [gmig_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [gmig_pkg::RSP_USER_W-1:0]   rsp_tuser,   // [1:0] status
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gmig_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  gmig_pkg::cfg_type                 csr_wdata
);
   import gmig_pkg::*;

   geom_type  geom;
   logic      geom_busy;
   logic      csr_hit, req_fire, restart;

   phase_type phase_ff, phase_in, cur_phase;
   logic      second_half_ff, second_half_in, cur_half;
   count_type layer_counter_ff, layer_counter_in, cur_layer;
   count_type row_counter_ff, row_counter_in, cur_row;
   count_type column_counter_ff, column_counter_in, cur_col;
   index_type base_index_ff, base_index_in, cur_base;
   index_type row_base_ff, row_base_in, cur_row_base;

   logic      rsp_tvalid_ff;
   index_type tri0_a_ff, tri0_b_ff, tri0_c_ff, tri1_a_ff, tri1_b_ff, tri1_c_ff;
   index_type tri0_a_in, tri0_b_in, tri0_c_in, tri1_a_in, tri1_b_in, tri1_c_in;
   logic [IDX_COUNT_W-1:0] count_ff, count_in;
   logic      last_ff, last_in;
   status_type status_ff, status_in;

   index_type ia, ib, ic, id, x_ext, next_base;
   logic      col_more, row_more_cell, row_more_side, layer_more_cell, layer_more_side;
   logic      do_enter;
   phase_type enter_phase;

   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && csr_ready
                   && ((csr_index == CSR_X_COUNT) || (csr_index == CSR_ROWS)
                    || (csr_index == CSR_LAYERS));

   gmig_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_hit),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom),
      .busy      (geom_busy)
   );

   assign req_tready = !geom_busy && (!rsp_tvalid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign restart    = req_tdata[0];

   // restart behaves as if the pass were entered just before this step
   always_comb begin
      if (restart) begin
         cur_phase    = geom.start_phase;
         cur_half     = 1'b0;
         cur_layer    = '0;
         cur_row      = '0;
         cur_col      = '0;
         cur_base     = '0;
         cur_row_base = '0;
      end else begin
         cur_phase    = phase_ff;
         cur_half     = second_half_ff;
         cur_layer    = layer_counter_ff;
         cur_row      = row_counter_ff;
         cur_col      = column_counter_ff;
         cur_base     = base_index_ff;
         cur_row_base = row_base_ff;
      end
   end

   assign x_ext     = index_type'(geom.x_count);
   assign next_base = cur_base + geom.layer_points;

   assign col_more        = ({1'b0, cur_col} + 13'd1) < geom.x_minus_1;
   assign row_more_cell   = ({1'b0, cur_row} + 13'd2) < geom.rows;
   assign row_more_side   = row_more_cell;
   assign layer_more_cell = ({1'b0, cur_layer} + 13'd1) < geom.layers;
   assign layer_more_side = ({1'b0, cur_layer} + 13'd2) < geom.layers;

   // corner indices of the current primitive
   always_comb begin
      ia = '0;
      ib = '0;
      ic = '0;
      id = '0;
      case (cur_phase)
         PH_LINE: begin
            ia = index_type'(cur_col);
            ib = ia + index_type'(1);
         end
         PH_CELL: begin
            ia = cur_row_base + index_type'(cur_col);
            ib = ia + index_type'(1);
            ic = ia + x_ext;
            id = ic + index_type'(1);
         end
         PH_FB: begin
            ia = cur_base + index_type'(cur_col)
               + (cur_half ? geom.points_minus_x : '0);
            ib = ia + index_type'(1);
            ic = ia + geom.layer_points;
            id = ic + index_type'(1);
         end
         PH_LR: begin
            ia = cur_row_base + (cur_half ? index_type'(geom.x_minus_1) : '0);
            ib = ia + x_ext;
            ic = ia + geom.layer_points;
            id = ic + x_ext;
         end
         default: begin
            ia = '0;
         end
      endcase
   end

   // step to the next primitive
   always_comb begin
      phase_in          = cur_phase;
      second_half_in    = cur_half;
      layer_counter_in  = cur_layer;
      row_counter_in    = cur_row;
      column_counter_in = cur_col;
      base_index_in     = cur_base;
      row_base_in       = cur_row_base;
      do_enter          = 1'b0;
      enter_phase       = PH_DONE;
      case (cur_phase)
         PH_LINE: begin
            if (col_more) begin
               column_counter_in = cur_col + 12'd1;
            end else begin
               do_enter = 1'b1;
            end
         end
         PH_CELL: begin
            if (col_more) begin
               column_counter_in = cur_col + 12'd1;
            end else begin
               column_counter_in = '0;
               if (row_more_cell) begin
                  row_counter_in = cur_row + 12'd1;
                  row_base_in    = cur_row_base + x_ext;
               end else begin
                  row_counter_in = '0;
                  if (layer_more_cell) begin
                     layer_counter_in = cur_layer + 12'd1;
                     base_index_in    = next_base;
                     row_base_in      = next_base;
                  end else begin
                     do_enter    = 1'b1;
                     enter_phase = geom.after_cell_phase;
                  end
               end
            end
         end
         PH_FB, PH_LR: begin
            if (!cur_half) begin
               second_half_in = 1'b1;
            end else begin
               second_half_in = 1'b0;
               if ((cur_phase == PH_FB) && col_more) begin
                  column_counter_in = cur_col + 12'd1;
               end else if ((cur_phase == PH_LR) && row_more_side) begin
                  row_counter_in = cur_row + 12'd1;
                  row_base_in    = cur_row_base + x_ext;
               end else begin
                  column_counter_in = '0;
                  row_counter_in    = '0;
                  row_base_in       = cur_base;
                  if (layer_more_side) begin
                     layer_counter_in = cur_layer + 12'd1;
                     base_index_in    = next_base;
                     row_base_in      = next_base;
                  end else begin
                     do_enter    = 1'b1;
                     enter_phase = (cur_phase == PH_FB) ? geom.after_fb_phase : PH_DONE;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
      if (do_enter || !geom.ok) begin
         phase_in          = geom.ok ? enter_phase : PH_DONE;
         second_half_in    = 1'b0;
         layer_counter_in  = '0;
         row_counter_in    = '0;
         column_counter_in = '0;
         base_index_in     = '0;
         row_base_in       = '0;
      end
   end

   // response fields
   always_comb begin
      tri0_a_in = '0;
      tri0_b_in = '0;
      tri0_c_in = '0;
      tri1_a_in = '0;
      tri1_b_in = '0;
      tri1_c_in = '0;
      count_in  = IDX_NONE;
      last_in   = 1'b0;
      if (!geom.ok) begin
         status_in = ST_BAD_GEOMETRY;
      end else if (cur_phase == PH_DONE) begin
         status_in = ST_EXHAUSTED;
      end else begin
         status_in = ST_OK;
         last_in   = (phase_in == PH_DONE);
         tri0_a_in = ia;
         tri0_b_in = ib;
         if (cur_phase == PH_LINE) begin
            count_in = IDX_SEGMENT;
         end else begin
            count_in  = IDX_QUAD;
            tri0_c_in = ic;
            tri1_a_in = id;
            tri1_b_in = ic;
            tri1_c_in = ib;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_DONE;
         second_half_ff    <= 1'b0;
         layer_counter_ff  <= '0;
         row_counter_ff    <= '0;
         column_counter_ff <= '0;
         base_index_ff     <= '0;
         row_base_ff       <= '0;
      end else if (csr_hit) begin
         phase_ff          <= PH_DONE;
         second_half_ff    <= 1'b0;
         layer_counter_ff  <= '0;
         row_counter_ff    <= '0;
         column_counter_ff <= '0;
         base_index_ff     <= '0;
         row_base_ff       <= '0;
      end else if (req_fire) begin
         phase_ff          <= phase_in;
         second_half_ff    <= second_half_in;
         layer_counter_ff  <= layer_counter_in;
         row_counter_ff    <= row_counter_in;
         column_counter_ff <= column_counter_in;
         base_index_ff     <= base_index_in;
         row_base_ff       <= row_base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         tri0_a_ff <= tri0_a_in;
         tri0_b_ff <= tri0_b_in;
         tri0_c_ff <= tri0_c_in;
         tri1_a_ff <= tri1_a_in;
         tri1_b_ff <= tri1_b_in;
         tri1_c_ff <= tri1_c_in;
         count_ff  <= count_in;
         last_ff   <= last_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'({count_ff, tri1_c_ff, tri1_b_ff, tri1_a_ff,
                                    tri0_c_ff, tri0_b_ff, tri0_a_ff});
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

   a_no_indices_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (status_ff != ST_OK)) |-> ((count_ff == IDX_NONE) && !last_ff))
      else $error("error response carries indices");

   a_write_stalls_requests: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> !req_tready)
      else $error("request taken before geometry settled");

   a_pass_needs_good_geometry: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_DONE) |-> geom.ok)
      else $error("pass active with bad geometry");

   a_line_counters: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LINE) |-> ((layer_counter_ff == '0) && (row_counter_ff == '0)
                                && !second_half_ff))
      else $error("segment pass with stray counters");

endmodule
`default_nettype wire

// ===== tb/mesh_index_checker.sv =====
`timescale 1ns / 100ps
module mesh_index_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [gmig_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] restart
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [23:0] tri0_a, [47:24] tri0_b, [71:48] tri0_c, [95:72] tri1_a,
   // [119:96] tri1_b, [143:120] tri1_c, [146:144] index_count
   input  logic [gmig_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic [gmig_pkg::RSP_USER_W-1:0]   rsp_tuser,   // [1:0] status
   input  logic                              rsp_tlast,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [gmig_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  gmig_pkg::cfg_type                 csr_wdata,
   output int                                error_count,
   output int                                outstanding
);
   import gmig_pkg::*;

   typedef struct packed {
      logic [5:0][INDEX_WIDTH-1:0] corner;
      logic [IDX_COUNT_W-1:0]      index_count;
      logic                        last;
      status_type                  status;
   } mesh_prim_type;

   string corner_name [6] = '{"tri0_a", "tri0_b", "tri0_c", "tri1_a", "tri1_b", "tri1_c"};

   mesh_prim_type   expected_prims [$];
   int              mismatches = 0;

   // grid registers
   cfg_type         grid_x;
   cfg_type         grid_rows;
   cfg_type         grid_layers;

   // position of the walk over the grid
   phase_type       walk_phase;
   bit              far_side;
   int unsigned     layer_pos;
   int unsigned     row_pos;
   int unsigned     col_pos;
   longint unsigned layer_base;
   longint unsigned layer_points;

   function automatic bit geometry_valid();
      longint unsigned total;
      if (grid_x < 1 || grid_x > CFG_MAX) return 1'b0;
      if (grid_rows < 1 || grid_rows > CFG_MAX) return 1'b0;
      if (grid_layers < 1 || grid_layers > CFG_MAX) return 1'b0;
      if (grid_rows == 1 && grid_layers > 1) return 1'b0;
      total = grid_x;
      total = total * grid_rows * grid_layers;
      return total <= MAX_POINTS;
   endfunction

   function automatic bit phase_is_empty(input phase_type p);
      case (p)
         PH_LINE: return grid_x < 2;
         PH_CELL: return grid_x < 2 || grid_rows < 2;
         PH_FB:   return grid_layers < 2 || grid_x < 2;
         PH_LR:   return grid_layers < 2 || grid_rows < 2;
         default: return 1'b0;
      endcase
   endfunction

   function automatic phase_type phase_after(input phase_type p);
      if (p == PH_CELL) return (grid_layers > 1) ? PH_FB : PH_DONE;
      if (p == PH_FB) return PH_LR;
      return PH_DONE;
   endfunction

   function automatic void enter_phase(input phase_type target);
      phase_type p;
      p = target;
      // skip phases that have nothing to emit for this grid
      while (p != PH_DONE && phase_is_empty(p)) p = phase_after(p);
      walk_phase = p;
      far_side   = 1'b0;
      layer_pos  = 0;
      row_pos    = 0;
      col_pos    = 0;
      layer_base = 0;
   endfunction

   function automatic void advance_walk();
      int unsigned last_col;
      int unsigned last_row;
      bit          rolled;
      last_col = grid_x - 1;
      last_row = grid_rows - 1;
      case (walk_phase)
         PH_LINE: begin
            if (col_pos + 1 < last_col) col_pos++;
            else enter_phase(PH_DONE);
         end
         PH_CELL: begin
            if (col_pos + 1 < last_col) col_pos++;
            else begin
               col_pos = 0;
               if (row_pos + 1 < last_row) row_pos++;
               else begin
                  row_pos = 0;
                  if (layer_pos + 1 < grid_layers) begin
                     layer_pos++;
                     layer_base += layer_points;
                  end else begin
                     enter_phase(phase_after(PH_CELL));
                  end
               end
            end
         end
         default: begin
            // face phases: near face, then far face, then the next position
            if (!far_side) far_side = 1'b1;
            else begin
               far_side = 1'b0;
               rolled   = 1'b1;
               if (walk_phase == PH_FB) begin
                  if (col_pos + 1 < last_col) begin
                     col_pos++;
                     rolled = 1'b0;
                  end else begin
                     col_pos = 0;
                  end
               end else begin
                  if (row_pos + 1 < last_row) begin
                     row_pos++;
                     rolled = 1'b0;
                  end else begin
                     row_pos = 0;
                  end
               end
               if (rolled) begin
                  // side faces span layer pairs, so one fewer than the layers
                  if (layer_pos + 1 < grid_layers - 1) begin
                     layer_pos++;
                     layer_base += layer_points;
                  end else begin
                     enter_phase(phase_after(walk_phase));
                  end
               end
            end
         end
      endcase
   endfunction

   function automatic mesh_prim_type predict_prim(input logic restart);
      mesh_prim_type   prim;
      longint unsigned a, b, c, d, xw;
      prim = '0;
      a = 0;
      b = 0;
      c = 0;
      d = 0;
      xw = grid_x;
      if (!geometry_valid()) begin
         enter_phase(PH_DONE);
         prim.status = ST_BAD_GEOMETRY;
         return prim;
      end
      if (restart) begin
         layer_points = xw * grid_rows;
         enter_phase((grid_rows == 1 && grid_layers == 1) ? PH_LINE : PH_CELL);
      end
      if (walk_phase == PH_DONE) begin
         prim.status = ST_EXHAUSTED;
         return prim;
      end
      prim.index_count = IDX_QUAD;
      case (walk_phase)
         PH_LINE: begin
            a = col_pos;
            b = a + 1;
            prim.index_count = IDX_SEGMENT;
         end
         PH_CELL: begin
            a = layer_base + row_pos * xw + col_pos;
            b = a + 1;
            c = a + xw;
            d = c + 1;
         end
         PH_FB: begin
            a = layer_base + col_pos;
            if (far_side) a += layer_points - xw;
            b = a + 1;
            c = a + layer_points;
            d = c + 1;
         end
         default: begin
            a = layer_base + row_pos * xw;
            if (far_side) a += xw - 1;
            b = a + xw;
            c = a + layer_points;
            d = c + xw;
         end
      endcase
      prim.corner[0] = index_type'(a);
      prim.corner[1] = index_type'(b);
      if (prim.index_count == IDX_QUAD) begin
         // second triangle is (d, c, b)
         prim.corner[2] = index_type'(c);
         prim.corner[3] = index_type'(d);
         prim.corner[4] = index_type'(c);
         prim.corner[5] = index_type'(b);
      end
      advance_walk();
      prim.last   = (walk_phase == PH_DONE);
      prim.status = ST_OK;
      return prim;
   endfunction

   function automatic void write_register(input logic [CSR_INDEX_W-1:0] idx, input cfg_type value);
      case (idx)
         CSR_X_COUNT: grid_x = value;
         CSR_ROWS:    grid_rows = value;
         CSR_LAYERS:  grid_layers = value;
         default:     return;
      endcase
      enter_phase(PH_DONE);
   endfunction

   function automatic void reset_grid();
      grid_x       = 2;
      grid_rows    = 1;
      grid_layers  = 1;
      layer_points = 0;
      enter_phase(PH_DONE);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : track
      mesh_prim_type want;
      if (reset) begin
         reset_grid();
         expected_prims.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_prims.size() == 0) begin
               $error("response with no request pending");
               mismatches++;
            end else begin
               want = expected_prims.pop_front();
               for (int k = 0; k < 6; k++)
                  check_field(corner_name[k], want.corner[k],
                              rsp_tdata[k*INDEX_WIDTH +: INDEX_WIDTH]);
               check_field("index_count", want.index_count,
                           rsp_tdata[6*INDEX_WIDTH +: IDX_COUNT_W]);
               check_field("last", want.last, rsp_tlast);
               check_field("status", want.status, rsp_tuser);
            end
         end
         if (csr_valid && csr_ready) write_register(csr_index, csr_wdata);
         if (req_tvalid && req_tready)
            expected_prims.insert(expected_prims.size(), predict_prim(req_tdata[0]));
      end
      error_count <= mismatches;
      outstanding <= expected_prims.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
   import gmig_pkg::*;

   localparam int ITEM_TARGET = 1500;
   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_GAP     = 18;
   localparam int LONG_STALL  = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;    // [0] restart
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [23:0] tri0_a, [47:24] tri0_b, [71:48] tri0_c, [95:72] tri1_a,
   // [119:96] tri1_b, [143:120] tri1_c, [146:144] index_count
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;         // [1:0] status
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   cfg_type                csr_wdata = '0;

   int                     error_count;
   int                     outstanding;
   int                     requests_sent = 0;
   bit                     tx_steady = 1'b0;
   bit                     rx_steady = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   grid_mesh_index_generator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mesh_index_checker mesh_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   task automatic send_request(input logic restart);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, restart};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   task automatic run_pass(input int count, input logic restart_first);
      send_request(restart_first);
      repeat (count - 1) send_request(1'b0);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_geometry(input cfg_type x, input cfg_type rows, input cfg_type layers);
      csr_index_type reg_order [3];
      cfg_type       reg_value [3];
      reg_order = '{CSR_X_COUNT, CSR_ROWS, CSR_LAYERS};
      reg_value = '{x, rows, layers};
      drain_responses();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_order[i];
         csr_wdata <= reg_value[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      cfg_type gx, gr, gl;
      int      kind;
      int      phase_items;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: nothing in progress, then the single segment
      run_pass(1, 1'b0);
      run_pass(2, 1'b1);
      // single column: only the side faces, left and right coincide
      set_geometry(1, 3, 2);
      run_pass(5, 1'b1);
      // every phase of a layered grid, then exhausted
      set_geometry(2, 2, 2);
      run_pass(7, 1'b1);
      set_geometry(0, 1, 1);
      run_pass(1, 1'b1);
      set_geometry(4096, 4096, 2);
      run_pass(1, 1'b1);
      set_geometry(3, 1, 2);
      run_pass(1, 1'b1);
      set_geometry(8191, 1, 1);
      run_pass(1, 1'b1);
      set_geometry(1, 1, 1);
      run_pass(1, 1'b1);
      set_geometry(4096, 4096, 1);
      run_pass(2, 1'b1);
      set_geometry(4096, 1, 1);
      run_pass(2, 1'b1);

      while (requests_sent < ITEM_TARGET) begin
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            gx = cfg_type'($urandom_range(0, 8191));
            gr = cfg_type'($urandom_range(0, 8191));
            gl = cfg_type'($urandom_range(0, 8191));
         end else if (kind == 1) begin
            gx = cfg_type'($urandom_range(1, 4096));
            gr = cfg_type'($urandom_range(1, 4096));
            gl = cfg_type'($urandom_range(1, 3));
         end else begin
            gx = cfg_type'($urandom_range(1, 6));
            gr = cfg_type'($urandom_range(1, 5));
            gl = (gr == 1 && $urandom_range(0, 7) != 0) ? cfg_type'(1)
                                                          : cfg_type'($urandom_range(1, 4));
         end
         // now and then keep the pass going across a phase
         if ($urandom_range(0, 4) != 0) set_geometry(gx, gr, gl);
         phase_items = $urandom_range(10, 80);
         send_request($urandom_range(0, 7) != 0);
         repeat (phase_items - 1) send_request($urandom_range(0, 49) == 0);
      end

      drain_responses();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : response_sink
      int gap;
      int taken;
      taken = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         // long hold-offs let the block fill and back up the request side
         if (taken == 200 || taken == 1000) gap = LONG_STALL;
         else gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule
